// ===== sv/i2w_pkg.sv =====
`timescale 1ns / 1ps

package i2w_pkg;

    localparam int VALUE_W = 31;
    localparam int DIGIT_W = 4;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = DIGITS * DIGIT_W;
    localparam int GRP_W   = 3 * DIGIT_W;
    localparam int GROUPS  = 4;
    localparam int PAD_W   = GROUPS * GRP_W;
    localparam int CODE_W  = 5;
    localparam int CNT_W   = $clog2(VALUE_W);
    localparam int STEP_W  = 3;

    typedef logic [CODE_W-1:0] t_word;
    typedef logic [DIGIT_W-1:0] t_digit;

    localparam t_word W_ZERO      = t_word'(0);
    localparam t_word W_TEN       = t_word'(10);
    localparam t_word W_TENS_BASE = t_word'(18);
    localparam t_word W_HUNDRED   = t_word'(28);
    localparam t_word W_SCALE_0   = t_word'(28);

    // Micro-operations. Each one tests the current group and may put one token.
    localparam logic [2:0] OP_CHK   = 3'd0;
    localparam logic [2:0] OP_HDIG  = 3'd1;
    localparam logic [2:0] OP_HWORD = 3'd2;
    localparam logic [2:0] OP_TEEN  = 3'd3;
    localparam logic [2:0] OP_TENS  = 3'd4;
    localparam logic [2:0] OP_ONES  = 3'd5;
    localparam logic [2:0] OP_SCALE = 3'd6;
    localparam logic [2:0] OP_NEXT  = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [STEP_W-1:0] target;
    } t_uop;

    // Control store: one pass over a three-digit group. The check step skips
    // to the group end when the group is zero; the last step loops back.
    function automatic t_uop uc_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            3'd0: u = '{op: OP_CHK,   target: 3'd7};
            3'd1: u = '{op: OP_HDIG,  target: 3'd0};
            3'd2: u = '{op: OP_HWORD, target: 3'd0};
            3'd3: u = '{op: OP_TEEN,  target: 3'd0};
            3'd4: u = '{op: OP_TENS,  target: 3'd0};
            3'd5: u = '{op: OP_ONES,  target: 3'd0};
            3'd6: u = '{op: OP_SCALE, target: 3'd0};
            3'd7: u = '{op: OP_NEXT,  target: 3'd0};
            default: u = '{op: OP_NEXT, target: 3'd0};
        endcase
        return u;
    endfunction

endpackage

// ===== sv/i2w_bcd.sv =====
`timescale 1ns / 1ps

// Shift-and-add-three binary to decimal converter, one input bit per cycle.
module i2w_bcd (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [i2w_pkg::VALUE_W-1:0]      i_value,
    output logic                             o_done,
    output logic [i2w_pkg::BCD_W-1:0]        o_bcd
);

    logic [i2w_pkg::VALUE_W-1:0] r_bin, n_bin;
    logic [i2w_pkg::BCD_W-1:0]   r_bcd, n_bcd;
    logic [i2w_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [i2w_pkg::BCD_W-1:0]   adj;

    always_comb begin
        for (int d = 0; d < i2w_pkg::DIGITS; d++) begin
            if (r_bcd[d*i2w_pkg::DIGIT_W +: i2w_pkg::DIGIT_W] >= i2w_pkg::t_digit'(5)) begin
                adj[d*i2w_pkg::DIGIT_W +: i2w_pkg::DIGIT_W] =
                    r_bcd[d*i2w_pkg::DIGIT_W +: i2w_pkg::DIGIT_W] + i2w_pkg::t_digit'(3);
            end else begin
                adj[d*i2w_pkg::DIGIT_W +: i2w_pkg::DIGIT_W] =
                    r_bcd[d*i2w_pkg::DIGIT_W +: i2w_pkg::DIGIT_W];
            end
        end
    end

    always_comb begin
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_bin  = i_value;
            n_bcd  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd = {adj[i2w_pkg::BCD_W-2:0], r_bin[i2w_pkg::VALUE_W-1]};
            n_bin = {r_bin[i2w_pkg::VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + i2w_pkg::CNT_W'(1);
            if (r_cnt == i2w_pkg::CNT_W'(i2w_pkg::VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== sv/integer_to_word_tokens.sv =====
`timescale 1ns / 1ps
// A nonzero value is first converted to decimal digits, then handed to the sequencer,
// which walks the control store one group at a time, from billions down to units.
// A new value is taken only once the sequencer is back in idle. A nonzero group walks
// every control-store step, a zero group only the check step and the group-end step,
// and a step that puts a token waits while the output is stalled.
// Reset (synchronous, active low) returns the sequencer to idle and drops the output valid.

module integer_to_word_tokens (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [i2w_pkg::VALUE_W-1:0]       i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [i2w_pkg::CODE_W-1:0]        o_word_code,
    output logic                              o_last_word
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_ZERO = 2'd2;
    localparam logic [1:0] S_RUN  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [i2w_pkg::STEP_W-1:0]  r_step, n_step;
    logic [1:0]                  r_grp, n_grp;
    logic                        r_out_valid, n_out_valid;
    i2w_pkg::t_word              r_code, n_code;
    logic                        r_last, n_last;
    logic                        r_sent_last, n_sent_last;

    logic                        conv_start;
    logic                        conv_done;
    logic [i2w_pkg::BCD_W-1:0]   bcd;
    logic [i2w_pkg::PAD_W-1:0]   pad;
    logic [i2w_pkg::GRP_W-1:0]   grp;
    i2w_pkg::t_digit             dig_h, dig_t, dig_o;
    logic                        lower_zero;
    logic                        grp_zero;
    logic                        can_put;
    logic                        put;
    logic                        emit;
    i2w_pkg::t_word              e_code;
    logic                        e_last;
    i2w_pkg::t_uop               uop;

    // The value is converted to ten decimal digits before the sequencer walks it.
    i2w_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_value (i_value),
        .o_done  (conv_done),
        .o_bcd   (bcd)
    );

    assign pad = {{(i2w_pkg::PAD_W - i2w_pkg::BCD_W){1'b0}}, bcd};

    // Pick out the current group (billions, millions, thousands or units) and
    // check whether every digit below it is zero, which decides the last flag
    // on its scale word.
    always_comb begin
        case (r_grp)
            2'd0: begin
                grp        = pad[0 +: i2w_pkg::GRP_W];
                lower_zero = 1'b1;
            end
            2'd1: begin
                grp        = pad[i2w_pkg::GRP_W +: i2w_pkg::GRP_W];
                lower_zero = (pad[i2w_pkg::GRP_W-1:0] == '0);
            end
            2'd2: begin
                grp        = pad[2*i2w_pkg::GRP_W +: i2w_pkg::GRP_W];
                lower_zero = (pad[2*i2w_pkg::GRP_W-1:0] == '0);
            end
            default: begin
                grp        = pad[3*i2w_pkg::GRP_W +: i2w_pkg::GRP_W];
                lower_zero = (pad[3*i2w_pkg::GRP_W-1:0] == '0);
            end
        endcase
    end

    assign dig_h    = grp[3*i2w_pkg::DIGIT_W-1:2*i2w_pkg::DIGIT_W];
    assign dig_t    = grp[2*i2w_pkg::DIGIT_W-1:i2w_pkg::DIGIT_W];
    assign dig_o    = grp[i2w_pkg::DIGIT_W-1:0];
    assign grp_zero = (grp == '0);
    assign uop      = i2w_pkg::uc_rom(r_step);

    // Token decode for the current control word. Inside the units group a
    // token is the final one when no later digit of the group would speak;
    // in a higher group the scale word always follows.
    always_comb begin
        emit   = 1'b0;
        e_code = i2w_pkg::W_ZERO;
        e_last = 1'b0;
        case (uop.op)
            i2w_pkg::OP_HDIG: begin
                emit   = (dig_h != '0);
                e_code = i2w_pkg::t_word'(dig_h);
            end
            i2w_pkg::OP_HWORD: begin
                emit   = (dig_h != '0);
                e_code = i2w_pkg::W_HUNDRED;
                e_last = (r_grp == 2'd0) && (dig_t == '0) && (dig_o == '0);
            end
            i2w_pkg::OP_TEEN: begin
                emit   = (dig_t == i2w_pkg::t_digit'(1));
                e_code = i2w_pkg::W_TEN + i2w_pkg::t_word'(dig_o);
                e_last = (r_grp == 2'd0);
            end
            i2w_pkg::OP_TENS: begin
                emit   = (dig_t >= i2w_pkg::t_digit'(2));
                e_code = i2w_pkg::W_TENS_BASE + i2w_pkg::t_word'(dig_t);
                e_last = (r_grp == 2'd0) && (dig_o == '0);
            end
            i2w_pkg::OP_ONES: begin
                emit   = (dig_t != i2w_pkg::t_digit'(1)) && (dig_o != '0);
                e_code = i2w_pkg::t_word'(dig_o);
                e_last = (r_grp == 2'd0);
            end
            i2w_pkg::OP_SCALE: begin
                emit   = (r_grp != 2'd0);
                e_code = i2w_pkg::W_SCALE_0 + i2w_pkg::t_word'(r_grp);
                e_last = lower_zero;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // The output register frees up in the same cycle that its token is taken.
    assign can_put = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_grp       = r_grp;
        n_out_valid = r_out_valid && i_out_stall;
        n_code      = r_code;
        n_last      = r_last;
        n_sent_last = r_sent_last;
        conv_start  = 1'b0;
        put         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sent_last = 1'b0;
                    if (i_value == '0) begin
                        n_state = S_ZERO;
                    end else begin
                        conv_start = 1'b1;
                        n_state    = S_CONV;
                    end
                end
            end
            S_CONV: begin
                if (conv_done) begin
                    n_state = S_RUN;
                    n_step  = '0;
                    n_grp   = 2'(i2w_pkg::GROUPS - 1);
                end
            end
            S_ZERO: begin
                if (can_put) begin
                    put         = 1'b1;
                    n_out_valid = 1'b1;
                    n_code      = i2w_pkg::W_ZERO;
                    n_last      = 1'b1;
                    n_sent_last = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RUN: begin
                // A step that puts a token waits for room; other steps never wait.
                if (!emit || can_put) begin
                    if (emit) begin
                        put         = 1'b1;
                        n_out_valid = 1'b1;
                        n_code      = e_code;
                        n_last      = e_last;
                        if (e_last) begin
                            n_sent_last = 1'b1;
                        end
                    end
                    case (uop.op)
                        i2w_pkg::OP_CHK: begin
                            n_step = grp_zero ? uop.target : r_step + i2w_pkg::STEP_W'(1);
                        end
                        i2w_pkg::OP_NEXT: begin
                            if (r_grp == 2'd0) begin
                                n_state = S_IDLE;
                            end else begin
                                n_grp  = r_grp - 2'd1;
                                n_step = uop.target;
                            end
                        end
                        default: begin
                            n_step = r_step + i2w_pkg::STEP_W'(1);
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_grp       <= '0;
            r_out_valid <= 1'b0;
            r_sent_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_grp       <= n_grp;
            r_out_valid <= n_out_valid;
            r_sent_last <= n_sent_last;
        end
        r_code <= n_code;
        r_last <= n_last;
    end

    // A new request is taken only when the sequencer has finished the previous one.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_word_code = r_code;
    assign o_last_word = r_last;

    // The final token must have gone out by the time the units group closes.
    a_last_before_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && uop.op == i2w_pkg::OP_NEXT && r_grp == 2'd0) |-> r_sent_last)
        else $error("run ended without a final token");

    // Nothing may follow the final token of a run.
    a_no_token_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && put) |-> !r_sent_last)
        else $error("token put after the final token");

    // The converter only finishes while the sequencer waits for it.
    a_conv_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_done |-> (r_state == S_CONV))
        else $error("conversion finished outside the conversion state");

    // An accepted request always leads away from idle on the next cycle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_CONV || r_state == S_ZERO))
        else $error("accepted request did not start a run");

endmodule
